// ----- hdl/tosm_pkg.sv -----
// Package with shared constants, codes and types of the timestamp-ordered stream merger.
`timescale 1ns / 1ps

package tosm_pkg;

    localparam int NPORTS      = 8;
    localparam int TAG_BITS    = 16;
    localparam int MAX_RESULTS = 9;
    localparam int IDX_W       = (NPORTS > 1) ? $clog2(NPORTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int PORT_W      = 3;
    localparam int TIME_W      = 63;
    localparam int TAGF_W      = 16;
    localparam int AGE_W       = 17;
    localparam int TARDY_W     = 16;
    localparam int EV_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TIME_W-1:0]  END_OF_TIME   = {TIME_W{1'b1}};
    localparam logic [AGE_W-1:0]   AGE_MAX       = {AGE_W{1'b1}};
    localparam logic [TARDY_W-1:0] TARDY_RESET   = 16'd1000;

    localparam logic [EV_W-1:0] EV_FORWARD = 2'd0;
    localparam logic [EV_W-1:0] EV_DROPPED = 2'd1;
    localparam logic [EV_W-1:0] EV_REFUSED = 2'd2;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TARDY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DROP  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_SCAN,
        S_DECIDE,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic latch;
        logic apply;
        logic scan_clr;
        logic scan_step;
        logic fwd;
        logic push;
        logic push_last;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_last;
        logic blocked;
        logic found;
        logic pend_valid;
        logic out_free;
        logic cnt_full;
    } t_ctl_sts;

endpackage

// ----- hdl/tosm_ctrl.sv -----
// Controller state machine that sequences arrival handling, port scans and result hand-off.
`timescale 1ns / 1ps

module tosm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tosm_pkg::t_ctl_sts  i_sts,
    output tosm_pkg::t_ctl_cmd  o_cmd,
    output logic                o_in_ready
);

    tosm_pkg::t_state r_state;
    tosm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tosm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tosm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = tosm_pkg::S_APPLY;
                end
            end
            tosm_pkg::S_APPLY: begin
                o_cmd.apply    = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state        = tosm_pkg::S_SCAN;
            end
            tosm_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = tosm_pkg::S_DECIDE;
                end
            end
            tosm_pkg::S_DECIDE: begin
                if (i_sts.blocked || !i_sts.found || i_sts.cnt_full) begin
                    n_state = tosm_pkg::S_FLUSH;
                end else if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.fwd      = 1'b1;
                    o_cmd.push     = i_sts.pend_valid;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = tosm_pkg::S_SCAN;
                end
            end
            tosm_pkg::S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = tosm_pkg::S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_last = 1'b1;
                    n_state         = tosm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tosm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tosm_datapath.sv -----
// Datapath with port head slots, configuration, scan accumulators and result registers.
`timescale 1ns / 1ps

module tosm_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tosm_pkg::t_ctl_cmd                   i_cmd,
    output tosm_pkg::t_ctl_sts                   o_sts,
    input  logic                                 i_cfg_valid,
    input  logic [tosm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tosm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_command,
    input  logic [tosm_pkg::PORT_W-1:0]          i_port,
    input  logic [tosm_pkg::TIME_W-1:0]          i_start_time,
    input  logic [tosm_pkg::TAGF_W-1:0]          i_tag,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [tosm_pkg::EV_W-1:0]            o_event_res,
    output logic [tosm_pkg::PORT_W-1:0]          o_out_port,
    output logic [tosm_pkg::TIME_W-1:0]          o_out_time,
    output logic [tosm_pkg::TAGF_W-1:0]          o_out_tag,
    output logic                                 o_was_late,
    output logic                                 o_last
);

    localparam int NP   = tosm_pkg::NPORTS;
    localparam int IW   = tosm_pkg::IDX_W;
    localparam int TW   = tosm_pkg::TIME_W;
    localparam int TB   = tosm_pkg::TAG_BITS;
    localparam int AW   = tosm_pkg::AGE_W;

    logic          r_hv   [NP];
    logic [TW-1:0] r_ht   [NP];
    logic [TB-1:0] r_htag [NP];
    logic          r_hl   [NP];
    logic          r_seen [NP];
    logic [AW-1:0] r_age  [NP];
    logic [TW-1:0] r_lft;

    logic [tosm_pkg::TARDY_W-1:0] r_tardy;
    logic                         r_drop;

    logic                            r_cmd;
    logic [tosm_pkg::PORT_W-1:0]     r_port;
    logic [TW-1:0]                   r_time;
    logic [TB-1:0]                   r_tag;

    logic [IW-1:0] r_idx;
    logic          r_blk;
    logic          r_fnd;
    logic [IW-1:0] r_bidx;
    logic [TW-1:0] r_btime;

    logic                          r_pv;
    logic [tosm_pkg::EV_W-1:0]     r_pev;
    logic [tosm_pkg::PORT_W-1:0]   r_pport;
    logic [TW-1:0]                 r_ptime;
    logic [TB-1:0]                 r_ptag;
    logic                          r_plate;

    logic [tosm_pkg::CNT_W-1:0] r_cnt;

    logic                          r_ov;
    logic [tosm_pkg::EV_W-1:0]     r_oev;
    logic [tosm_pkg::PORT_W-1:0]   r_oport;
    logic [TW-1:0]                 r_otime;
    logic [TB-1:0]                 r_otag;
    logic                          r_olate;
    logic                          r_olast;

    logic          port_ok;
    logic [IW-1:0] pidx;
    logic          late;
    logic          out_free;
    logic          cur_blk;
    logic          cur_better;

    assign pidx     = IW'(r_port);
    assign port_ok  = (int'(r_port) < NP);
    assign late     = (r_lft < tosm_pkg::END_OF_TIME) && (r_time < tosm_pkg::END_OF_TIME) &&
                      (r_time < r_lft);
    assign out_free = !r_ov || i_out_ready;
    assign cur_blk  = !r_hv[r_idx] && r_seen[r_idx] &&
                      (r_age[r_idx] <= AW'(r_tardy));
    assign cur_better = r_hv[r_idx] && (r_ht[r_idx] < r_btime);

    assign o_sts.scan_last  = (r_idx == IW'(NP - 1));
    assign o_sts.blocked    = r_blk;
    assign o_sts.found      = r_fnd;
    assign o_sts.pend_valid = r_pv;
    assign o_sts.out_free   = out_free;
    assign o_sts.cnt_full   = (r_cnt == tosm_pkg::CNT_W'(tosm_pkg::MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tardy <= tosm_pkg::TARDY_RESET;
            r_drop  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tosm_pkg::REG_TARDY: r_tardy <= i_cfg_data[tosm_pkg::TARDY_W-1:0];
                tosm_pkg::REG_DROP:  r_drop  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= i_command;
            r_port <= i_port;
            r_time <= i_start_time;
            r_tag  <= TB'(i_tag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++) begin
                r_hv[p]   <= 1'b0;
                r_hl[p]   <= 1'b0;
                r_seen[p] <= 1'b0;
                r_age[p]  <= '0;
            end
            r_lft <= tosm_pkg::END_OF_TIME;
            r_pv  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.latch) begin
                r_cnt <= '0;
            end
            if (i_cmd.apply) begin
                if (r_cmd == tosm_pkg::CMD_ARRIVE) begin
                    if (port_ok) begin
                        if (r_hv[pidx]) begin
                            r_pv    <= 1'b1;
                            r_pev   <= tosm_pkg::EV_REFUSED;
                            r_pport <= r_port;
                            r_ptime <= r_time;
                            r_ptag  <= r_tag;
                            r_plate <= 1'b0;
                            r_cnt   <= r_cnt + 1'b1;
                        end else begin
                            r_seen[pidx] <= 1'b1;
                            r_age[pidx]  <= '0;
                            if (late && r_drop) begin
                                r_pv    <= 1'b1;
                                r_pev   <= tosm_pkg::EV_DROPPED;
                                r_pport <= r_port;
                                r_ptime <= r_time;
                                r_ptag  <= r_tag;
                                r_plate <= 1'b1;
                                r_cnt   <= r_cnt + 1'b1;
                            end else begin
                                r_hv[pidx]   <= 1'b1;
                                r_ht[pidx]   <= r_time;
                                r_htag[pidx] <= r_tag;
                                r_hl[pidx]   <= late;
                            end
                        end
                    end
                end else begin
                    for (int p = 0; p < NP; p++) begin
                        if (r_seen[p] && (r_age[p] < tosm_pkg::AGE_MAX)) begin
                            r_age[p] <= r_age[p] + 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.fwd) begin
                r_pv           <= 1'b1;
                r_pev          <= tosm_pkg::EV_FORWARD;
                r_pport        <= tosm_pkg::PORT_W'(r_bidx);
                r_ptime        <= r_btime;
                r_ptag         <= r_htag[r_bidx];
                r_plate        <= r_hl[r_bidx];
                r_cnt          <= r_cnt + 1'b1;
                r_hv[r_bidx]   <= 1'b0;
                r_hl[r_bidx]   <= 1'b0;
                r_ht[r_bidx]   <= tosm_pkg::END_OF_TIME;
                r_lft          <= r_btime;
            end else if (i_cmd.push_last) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_blk <= 1'b0;
            r_fnd <= 1'b0;
        end else if (i_cmd.scan_clr) begin
            r_idx   <= '0;
            r_blk   <= 1'b0;
            r_fnd   <= 1'b0;
            r_btime <= tosm_pkg::END_OF_TIME;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (cur_blk) begin
                r_blk <= 1'b1;
            end
            if (cur_better) begin
                r_fnd   <= 1'b1;
                r_bidx  <= r_idx;
                r_btime <= r_ht[r_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push) begin
            r_ov    <= 1'b1;
            r_oev   <= r_pev;
            r_oport <= r_pport;
            r_otime <= r_ptime;
            r_otag  <= r_ptag;
            r_olate <= r_plate;
            r_olast <= i_cmd.push_last;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_event_res = r_oev;
    assign o_out_port  = r_oport;
    assign o_out_time  = r_otime;
    assign o_out_tag   = tosm_pkg::TAGF_W'(r_otag);
    assign o_was_late  = r_olate;
    assign o_last      = r_olast;

endmodule

// ----- hdl/timestamp_ordered_stream_merger.sv -----
// Top level of the timestamp-ordered stream merger: controller and datapath.
`timescale 1ns / 1ps
// One item is taken at a time. An item goes through arrival handling and a first port scan,
// then a decision and a further port scan per forwarded message, then a final decision and
// the hand-over of any final result.
// Each forwarding step rests on a full port scan, which inspects one head slot per cycle.
// Synchronous active-low reset empties all ports, sets the last forwarded time to end of time,
// and loads the tardy window with 1000 and the drop policy with 1.

module timestamp_ordered_stream_merger (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_command,
    input  logic [tosm_pkg::PORT_W-1:0]          i_port,
    input  logic [tosm_pkg::TIME_W-1:0]          i_start_time,
    input  logic [tosm_pkg::TAGF_W-1:0]          i_tag,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [tosm_pkg::EV_W-1:0]            o_event_res,
    output logic [tosm_pkg::PORT_W-1:0]          o_out_port,
    output logic [tosm_pkg::TIME_W-1:0]          o_out_time,
    output logic [tosm_pkg::TAGF_W-1:0]          o_out_tag,
    output logic                                 o_was_late,
    output logic                                 o_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tosm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tosm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    tosm_pkg::t_ctl_cmd cmd;
    tosm_pkg::t_ctl_sts sts;

    assign o_cfg_ready = 1'b1;

    tosm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    tosm_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_command),
        .i_port       (i_port),
        .i_start_time (i_start_time),
        .i_tag        (i_tag),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_event_res  (o_event_res),
        .o_out_port   (o_out_port),
        .o_out_time   (o_out_time),
        .o_out_tag    (o_out_tag),
        .o_was_late   (o_was_late),
        .o_last       (o_last)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench of the timestamp-ordered stream merger with a scoreboard class.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int ITEMS_PER_SET  = 40;
    localparam int SETTLE_CYCLES  = 2 * (tosm_pkg::NPORTS + 2 +
                                         (tosm_pkg::NPORTS + 1) * tosm_pkg::MAX_RESULTS);
    localparam int WATCHDOG_LIMIT = 20 * SETTLE_CYCLES;

    typedef struct {
        logic [tosm_pkg::EV_W-1:0]   ev;
        logic [tosm_pkg::PORT_W-1:0] port;
        logic [tosm_pkg::TIME_W-1:0] stamp;
        logic [tosm_pkg::TAGF_W-1:0] tag;
        logic                        late;
        logic                        last;
    } t_merge_result;

    class t_merge_scoreboard;
        logic                           held [tosm_pkg::NPORTS];
        logic [tosm_pkg::TIME_W-1:0]    head_stamp [tosm_pkg::NPORTS];
        logic [tosm_pkg::TAGF_W-1:0]    head_tag [tosm_pkg::NPORTS];
        logic                           head_late [tosm_pkg::NPORTS];
        logic                           seen [tosm_pkg::NPORTS];
        logic [tosm_pkg::AGE_W-1:0]     age [tosm_pkg::NPORTS];
        logic [tosm_pkg::TIME_W-1:0]    last_fwd;
        logic [tosm_pkg::TARDY_W-1:0]   tardy;
        logic                           drop;
        t_merge_result                  expected_q [$];
        int                             mismatches;

        function new();
            for (int p = 0; p < tosm_pkg::NPORTS; p++) begin
                held[p]       = 1'b0;
                head_stamp[p] = tosm_pkg::END_OF_TIME;
                head_tag[p]   = '0;
                head_late[p]  = 1'b0;
                seen[p]       = 1'b0;
                age[p]        = '0;
            end
            last_fwd   = tosm_pkg::END_OF_TIME;
            tardy      = tosm_pkg::TARDY_RESET;
            drop       = 1'b1;
            mismatches = 0;
        endfunction

        function void write_reg(logic [tosm_pkg::CFG_IDX_W-1:0] idx,
                                logic [tosm_pkg::CFG_DATA_W-1:0] data);
            if (idx == tosm_pkg::REG_TARDY) begin
                tardy = data[tosm_pkg::TARDY_W-1:0];
            end else if (idx == tosm_pkg::REG_DROP) begin
                drop = data[0];
            end
        endfunction

        function bit blocked();
            for (int p = 0; p < tosm_pkg::NPORTS; p++) begin
                if (!held[p] && seen[p] && age[p] <= tosm_pkg::AGE_W'(tardy)) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_item(logic cmd, logic [tosm_pkg::PORT_W-1:0] port,
                                logic [tosm_pkg::TIME_W-1:0] stamp,
                                logic [tosm_pkg::TAGF_W-1:0] tag);
            t_merge_result               step [tosm_pkg::MAX_RESULTS];
            int                          n;
            int                          best;
            logic [tosm_pkg::TIME_W-1:0] best_stamp;
            logic                        late;
            n = 0;
            if (cmd == tosm_pkg::CMD_ARRIVE) begin
                if (held[port]) begin
                    step[n] = '{tosm_pkg::EV_REFUSED, port, stamp, tag, 1'b0, 1'b0};
                    n++;
                end else begin
                    late = (last_fwd != tosm_pkg::END_OF_TIME) &&
                           (stamp != tosm_pkg::END_OF_TIME) && (stamp < last_fwd);
                    seen[port] = 1'b1;
                    age[port]  = '0;
                    if (late && drop) begin
                        step[n] = '{tosm_pkg::EV_DROPPED, port, stamp, tag, 1'b1, 1'b0};
                        n++;
                    end else begin
                        held[port]       = 1'b1;
                        head_stamp[port] = stamp;
                        head_tag[port]   = tag;
                        head_late[port]  = late;
                    end
                end
            end else begin
                for (int p = 0; p < tosm_pkg::NPORTS; p++) begin
                    if (seen[p] && age[p] != tosm_pkg::AGE_MAX) begin
                        age[p] = age[p] + 1'b1;
                    end
                end
            end
            // Forward oldest heads, lowest port on ties, until blocked, empty or full.
            while (n < tosm_pkg::MAX_RESULTS && !blocked()) begin
                best       = -1;
                best_stamp = tosm_pkg::END_OF_TIME;
                for (int p = 0; p < tosm_pkg::NPORTS; p++) begin
                    if (held[p] && head_stamp[p] < best_stamp) begin
                        best       = p;
                        best_stamp = head_stamp[p];
                    end
                end
                if (best < 0) begin
                    break;
                end
                step[n] = '{tosm_pkg::EV_FORWARD, tosm_pkg::PORT_W'(best), best_stamp,
                            head_tag[best], head_late[best], 1'b0};
                n++;
                held[best]       = 1'b0;
                head_late[best]  = 1'b0;
                head_stamp[best] = tosm_pkg::END_OF_TIME;
                last_fwd         = best_stamp;
            end
            if (n > 0) begin
                step[n-1].last = 1'b1;
            end
            for (int k = 0; k < n; k++) begin
                expected_q.insert(expected_q.size(), step[k]);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_merge_result got);
            t_merge_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected, actual event %0d port %0d %s",
                         $time, got.ev, got.port, "was not expected");
                $display("%0t: actual start %0h tag %0h", $time, got.stamp, got.tag);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("event", want.ev, got.ev);
            compare_field("port", want.port, got.port);
            compare_field("start time", want.stamp, got.stamp);
            compare_field("tag", want.tag, got.tag);
            compare_field("late mark", want.late, got.late);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic                            i_command;
    logic [tosm_pkg::PORT_W-1:0]     i_port;
    logic [tosm_pkg::TIME_W-1:0]     i_start_time;
    logic [tosm_pkg::TAGF_W-1:0]     i_tag;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [tosm_pkg::EV_W-1:0]       o_event_res;
    logic [tosm_pkg::PORT_W-1:0]     o_out_port;
    logic [tosm_pkg::TIME_W-1:0]     o_out_time;
    logic [tosm_pkg::TAGF_W-1:0]     o_out_tag;
    logic                            o_was_late;
    logic                            o_last;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [tosm_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tosm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    t_merge_scoreboard           sb = new();
    bit                          quiet;
    int                          stall_cycles;
    logic [tosm_pkg::TIME_W-1:0] time_base;

    timestamp_ordered_stream_merger u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_port       (i_port),
        .i_start_time (i_start_time),
        .i_tag        (i_tag),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_res  (o_event_res),
        .o_out_port   (o_out_port),
        .o_out_time   (o_out_time),
        .o_out_tag    (o_out_tag),
        .o_was_late   (o_was_late),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin : monitor
        t_merge_result got;
        logic          moved;
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            moved = 1'b0;
            if (o_out_valid && i_out_ready) begin
                got = '{o_event_res, o_out_port, o_out_time, o_out_tag, o_was_late, o_last};
                sb.check_result(got);
                moved = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_item(i_command, i_port, i_start_time, i_tag);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (moved) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : out_ready_driver
        int burst;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 19);
                i_out_ready <= 1'b0;
                repeat (burst) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [tosm_pkg::TIME_W-1:0] wide_random();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[tosm_pkg::TIME_W-1:0];
    endfunction

    task automatic send_item(input logic cmd, input logic [tosm_pkg::PORT_W-1:0] port,
                             input logic [tosm_pkg::TIME_W-1:0] stamp,
                             input logic [tosm_pkg::TAGF_W-1:0] tag);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_port       <= port;
        i_start_time <= stamp;
        i_tag        <= tag;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Waits until every expected result has arrived and the block has gone quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [tosm_pkg::TARDY_W-1:0] tardy,
                                 input logic drop_on);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= tosm_pkg::REG_TARDY;
        i_cfg_data  <= tosm_pkg::CFG_DATA_W'(tardy);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= tosm_pkg::REG_DROP;
        i_cfg_data  <= (tosm_pkg::CFG_DATA_W'($urandom_range(0, 65535)) & 16'hFFFE) |
                       tosm_pkg::CFG_DATA_W'(drop_on);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly arrivals with rising times on empty ports; the rest is ticks, late,
    // refused, end-of-time and wildly timed arrivals.
    task automatic random_item();
        logic [tosm_pkg::PORT_W-1:0] free_ports [$];
        logic [tosm_pkg::PORT_W-1:0] port;
        logic [tosm_pkg::TIME_W-1:0] stamp;
        logic [tosm_pkg::TAGF_W-1:0] tag;
        int                          kind;
        int                          eot_held;
        eot_held = 0;
        for (int p = 0; p < tosm_pkg::NPORTS; p++) begin
            if (!sb.held[p]) begin
                free_ports.insert(free_ports.size(), tosm_pkg::PORT_W'(p));
            end else if (sb.head_stamp[p] == tosm_pkg::END_OF_TIME) begin
                eot_held++;
            end
        end
        kind = $urandom_range(0, 99);
        tag  = tosm_pkg::TAGF_W'($urandom_range(0, 65535));
        port = tosm_pkg::PORT_W'($urandom_range(0, tosm_pkg::NPORTS - 1));
        if (free_ports.size() != 0 && kind >= 12 && kind < 80) begin
            port = free_ports[$urandom_range(0, free_ports.size() - 1)];
        end
        stamp     = time_base + tosm_pkg::TIME_W'($urandom_range(0, 40));
        time_base = time_base + tosm_pkg::TIME_W'($urandom_range(0, 8));
        if (kind < 12) begin
            send_item(tosm_pkg::CMD_TICK, port, wide_random(), tag);
        end else begin
            if (kind >= 70 && kind < 80 && sb.last_fwd != tosm_pkg::END_OF_TIME) begin
                stamp = (sb.last_fwd > 64) ?
                        sb.last_fwd - tosm_pkg::TIME_W'($urandom_range(1, 64)) : '0;
            end else if (kind >= 88 && kind < 92) begin
                time_base = wide_random();
                stamp     = time_base;
            end else if (kind >= 92 && kind < 94 && eot_held < 2) begin
                stamp = tosm_pkg::END_OF_TIME;
            end else if (kind >= 94) begin
                stamp = wide_random();
            end
            send_item(tosm_pkg::CMD_ARRIVE, port, stamp, tag);
        end
    endtask

    initial begin : stimulus
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = tosm_pkg::CMD_ARRIVE;
        i_port       = '0;
        i_start_time = '0;
        i_tag        = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = tosm_pkg::REG_TARDY;
        i_cfg_data   = '0;
        quiet        = 1'b0;
        time_base    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(tosm_pkg::CMD_ARRIVE, 3'd0, 63'd100, 16'h0000);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd1, 63'h4000_0000_0000_0000, 16'hFFFF);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd2, 63'd300, 16'h1234);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd3, 63'd0, 16'h00FF);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd2, 63'd500, 16'hBEEF);
        send_item(tosm_pkg::CMD_TICK, 3'd0, 63'd0, 16'h0000);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd3, 63'd150, 16'h0F0F);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd0, 63'd120, 16'h8001);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd0, 63'h7FFF_FFFF_FFFF_FFFE, 16'h7FFE);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd4, tosm_pkg::END_OF_TIME, 16'hC3C3);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd4, 63'd200, 16'h3C3C);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd3, 63'd310, 16'h0001);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd5, 63'h7FFF_FFFF_0000_0000, 16'hA5A5);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd6, 63'd400, 16'h5A5A);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd7, 63'd50, 16'hFFFE);
        settle();
        load_settings(16'd0, 1'b0);
        send_item(tosm_pkg::CMD_TICK, 3'd7, tosm_pkg::END_OF_TIME, 16'hFFFF);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd2, 63'd10, 16'h2222);
        send_item(tosm_pkg::CMD_TICK, 3'd3, 63'd0, 16'h0000);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd6, 63'h5555_5555_5555_5555, 16'h5555);
        send_item(tosm_pkg::CMD_ARRIVE, 3'd1, 63'h2AAA_AAAA_AAAA_AAAA, 16'hAAAA);
        send_item(tosm_pkg::CMD_TICK, 3'd5, 63'h1234_5678_9ABC_DEF0, 16'h4321);

        for (int ph = 0; ph < 4; ph++) begin
            if (ph > 0) begin
                settle();
                load_settings((ph == 1) ? 16'hFFFF :
                              (ph == 2) ? 16'd5 :
                              tosm_pkg::TARDY_W'($urandom_range(0, 20)),
                              ph[0]);
            end
            time_base = (sb.last_fwd == tosm_pkg::END_OF_TIME) ? '0 : sb.last_fwd;
            for (int i = 0; i < ITEMS_PER_SET; i++) begin
                if (ph == 3 && i >= ITEMS_PER_SET - 25) begin
                    quiet = 1'b1;
                end
                random_item();
            end
        end
        settle();

        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tosm_pkg.sv
hdl/tosm_ctrl.sv
hdl/tosm_datapath.sv
hdl/timestamp_ordered_stream_merger.sv
sim/tb_top.sv
